// ----- src/u8dec_pkg.sv -----
// shared types and constants for the mixed latin-1 / utf-8 character decoder
package u8dec_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CodeW = 16;
  localparam int unsigned MaxRes = 3;
  localparam int unsigned CntW = 2;

  // decoder phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LEAD = 2'd1;
  localparam logic [1:0] PH_LEAD3 = 2'd2;
  localparam logic [1:0] PH_SECOND = 2'd3;

  localparam logic [CodeW-1:0] CODE_QMARK = 16'd63;
  localparam logic [CodeW-1:0] CODE_NUL = 16'd0;
  localparam logic [1:0] SKIP_FOUR = 2'd2;

  typedef logic [CodeW-1:0] code_t;
  typedef code_t [MaxRes-1:0] code_set_t;

endpackage

// ----- src/u8dec_byte_if.sv -----
// byte channel into the decoder
interface u8dec_byte_if;
  logic                         valid;
  logic                         ready;
  logic [u8dec_pkg::ByteW-1:0]  byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

// ----- src/u8dec_code_if.sv -----
// character code channel out of the decoder
interface u8dec_code_if;
  logic                         valid;
  logic                         ready;
  logic [u8dec_pkg::CodeW-1:0]  char_code;
  logic                         last_of_run;

  modport source (output valid, output char_code, output last_of_run, input ready);
  modport sink (input valid, input char_code, input last_of_run, output ready);
endinterface

// ----- src/utf8_latin1_char_decoder_unit.sv -----
// mixed latin-1 / utf-8 byte stream to character code decoder, top level
// One byte is taken per cycle while each byte gives at most one character code
// and the output is ready. Every byte is decoded in the cycle it is accepted and
// its codes (up to three) go into a three-entry buffer that drains one code per
// ready cycle; a byte with two or three codes holds off the next byte until its
// last code is taken. A byte's first code shows the cycle after it is accepted.
// A zero byte during the discard after a four-byte lead is passed on as code 0.
module utf8_latin1_char_decoder_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  u8dec_byte_if.sink            in_i,
  u8dec_code_if.source          out_o
);

  logic [1:0]                   phase_q, phase_d;
  logic [u8dec_pkg::ByteW-1:0]  lead_q, lead_d;
  logic [u8dec_pkg::ByteW-1:0]  second_q, second_d;
  logic [1:0]                   skip_q, skip_d;

  u8dec_pkg::code_set_t         res_q, res_d;
  u8dec_pkg::code_set_t         dec_codes;
  logic [u8dec_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic [u8dec_pkg::CntW-1:0]   dec_n;
  logic [u8dec_pkg::CntW-1:0]   pre_n;
  logic                         do_fresh;

  logic [u8dec_pkg::ByteW-1:0]  b;
  logic                         b_cont;
  logic                         accept;
  logic                         pop;

  assign b      = in_i.byte_in;
  assign b_cont = (b[7:6] == 2'b10);
  assign pop    = out_o.valid && out_o.ready;
  assign in_i.ready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_o.ready);
  assign accept = in_i.valid && in_i.ready;

  // decode of one byte against the held state
  always_comb begin
    phase_d   = phase_q;
    lead_d    = lead_q;
    second_d  = second_q;
    skip_d    = skip_q;
    dec_codes = '0;
    pre_n     = 2'd0;
    do_fresh  = 1'b0;
    dec_n     = 2'd0;

    if (skip_q != 2'd0) begin
      if (b == '0) begin
        skip_d       = 2'd0;
        dec_codes[0] = u8dec_pkg::CODE_NUL;
        pre_n        = 2'd1;
      end else begin
        skip_d = skip_q - 2'd1;
      end
    end else begin
      unique case (phase_q)
        u8dec_pkg::PH_LEAD: begin
          phase_d = u8dec_pkg::PH_IDLE;
          pre_n   = 2'd1;
          if (b_cont) begin
            if (lead_q[7:4] == 4'hF) begin
              dec_codes[0] = u8dec_pkg::CODE_QMARK;
              skip_d       = u8dec_pkg::SKIP_FOUR;
            end else begin
              dec_codes[0] = {5'd0, lead_q[4:0], b[5:0]};
            end
          end else begin
            dec_codes[0] = {8'd0, lead_q};
            do_fresh     = 1'b1;
          end
        end
        u8dec_pkg::PH_LEAD3: begin
          if (b_cont) begin
            second_d = b;
            phase_d  = u8dec_pkg::PH_SECOND;
          end else begin
            phase_d      = u8dec_pkg::PH_IDLE;
            dec_codes[0] = {8'd0, lead_q};
            pre_n        = 2'd1;
            do_fresh     = 1'b1;
          end
        end
        u8dec_pkg::PH_SECOND: begin
          phase_d = u8dec_pkg::PH_IDLE;
          if (b_cont) begin
            dec_codes[0] = {lead_q[3:0], second_q[5:0], b[5:0]};
            pre_n        = 2'd1;
          end else begin
            dec_codes[0] = {8'd0, lead_q};
            dec_codes[1] = {8'd0, second_q};
            pre_n        = 2'd2;
            do_fresh     = 1'b1;
          end
        end
        default: begin
          do_fresh = 1'b1;
        end
      endcase
    end

    dec_n = pre_n;
    if (do_fresh) begin
      if (b[7:6] != 2'b11) begin
        dec_codes[pre_n] = {8'd0, b};
        dec_n            = pre_n + 2'd1;
      end else if (b[7:4] == 4'hE) begin
        lead_d  = b;
        phase_d = u8dec_pkg::PH_LEAD3;
      end else begin
        lead_d  = b;
        phase_d = u8dec_pkg::PH_LEAD;
      end
    end
  end

  // result buffer, head in slot 0
  always_comb begin
    res_d = res_q;
    cnt_d = cnt_q;
    if (accept) begin
      res_d = dec_codes;
      cnt_d = dec_n;
    end else if (pop) begin
      res_d[0] = res_q[1];
      res_d[1] = res_q[2];
      cnt_d    = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= u8dec_pkg::PH_IDLE;
      lead_q   <= '0;
      second_q <= '0;
      skip_q   <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        phase_q  <= phase_d;
        lead_q   <= lead_d;
        second_q <= second_d;
        skip_q   <= skip_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o.valid       = (cnt_q != 2'd0);
  assign out_o.char_code   = res_q[0];
  assign out_o.last_of_run = (cnt_q == 2'd1);

  // buffer holds the codes of one byte only
  a_accept_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (cnt_q == 2'd0) || (cnt_q == 2'd1))
    else $error("byte accepted with codes of an earlier byte pending");

  // discard only runs from the idle phase
  a_skip_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skip_q != 2'd0) |-> (phase_q == u8dec_pkg::PH_IDLE))
    else $error("discard running with a lead held");

  // discard never grows once started
  a_skip_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skip_q != 2'd0) |=> (skip_q <= $past(skip_q)))
    else $error("discard count grew");

  // three-byte continuation phase holds a three-byte lead
  a_second_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == u8dec_pkg::PH_SECOND) |-> (lead_q[7:4] == 4'hE))
    else $error("second continuation awaited without three-byte lead");

endmodule
